@@ rtl/core/jda_pkg.sv @@
// ============================================================================
// jda_pkg - joystick direction angle shared definitions
// Types, constants and the tangent table used by the heading datapath.
// ============================================================================
`default_nettype none

package jda_pkg;

    // Heading and angle widths
    localparam int HEAD_W      = 9;
    localparam int KDEG_W      = 7;
    localparam int IDX_W       = 3;

    // Digit-serial multiplier and coordinate layout
    localparam int DIGIT_BITS     = 4;
    localparam int COORD_GUARD    = 8;
    localparam int COORD_HEADROOM = 3;
    localparam int TAN_TABLE_BITS = 24;
    localparam int TAN_W          = TAN_TABLE_BITS + 2;
    localparam int NUM_STEPS      = 7;

    // Angle constants
    localparam logic [KDEG_W-1:0] K_MAX   = 7'd89;
    localparam logic [KDEG_W-1:0] K_45    = 7'd45;
    localparam logic [HEAD_W-1:0] DEG_0   = 9'd0;
    localparam logic [HEAD_W-1:0] DEG_90  = 9'd90;
    localparam logic [HEAD_W-1:0] DEG_179 = 9'd179;
    localparam logic [HEAD_W-1:0] DEG_180 = 9'd180;
    localparam logic [HEAD_W-1:0] DEG_270 = 9'd270;
    localparam logic [HEAD_W-1:0] DEG_359 = 9'd359;
    localparam logic [HEAD_W-1:0] DEG_360 = 9'd360;

    // Register reset values
    localparam int CENTRE_RESET = 460;
    localparam int UPPER_RESET  = 900;
    localparam int LOWER_RESET  = 100;

    typedef enum logic [1:0] {
        REG_CENTRE = 2'd0,
        REG_UPPER  = 2'd1,
        REG_LOWER  = 2'd2,
        REG_NONE   = 2'd3
    } jda_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_KERN,
        ST_FIN
    } jda_state_t;

    typedef enum logic [1:0] {
        KS_IDLE,
        KS_MUL,
        KS_UPD
    } jda_kstate_t;

    // Step angles tested in turn, in degrees
    function automatic logic [KDEG_W-1:0] step_deg(input logic [IDX_W-1:0] idx);
        logic [KDEG_W-1:0] d;
        case (idx)
            3'd0:    d = 7'd64;
            3'd1:    d = 7'd32;
            3'd2:    d = 7'd16;
            3'd3:    d = 7'd8;
            3'd4:    d = 7'd4;
            3'd5:    d = 7'd2;
            3'd6:    d = 7'd1;
            default: d = 7'd0;
        endcase
        return d;
    endfunction

    // Tangent of the step angle with f fraction bits, rounded from 24 bits
    function automatic logic [TAN_W-1:0] tan_const(input logic [IDX_W-1:0] idx,
                                                   input int f);
        logic [TAN_W-1:0] base;
        logic [TAN_W:0]   rnd;
        int               sh;
        case (idx)
            3'd0:    base = 26'd34398390;
            3'd1:    base = 26'd10483568;
            3'd2:    base = 26'd4810789;
            3'd3:    base = 26'd2357884;
            3'd4:    base = 26'd1173177;
            3'd5:    base = 26'd585873;
            3'd6:    base = 26'd292847;
            default: base = '0;
        endcase
        sh = TAN_TABLE_BITS - f;
        if (sh <= 0) begin
            return base;
        end
        rnd = {1'b0, base} + ((TAN_W+1)'(1) << (sh - 1));
        return TAN_W'(rnd >> sh);
    endfunction

endpackage : jda_pkg

`default_nettype wire

@@ rtl/core/joystick_direction_angle.sv @@
// ============================================================================
// joystick_direction_angle - joystick sample pair to compass heading
// Converts one X/Y joystick sample pair into a heading in whole degrees.
// ============================================================================
//
//  channel   direction  handshake        payload
//  -------   ---------  ---------------  ------------------------------------
//  s_        in         s_valid/s_ready  s_x_sample, s_y_sample
//  m_        out        m_valid/m_ready  m_heading_deg
//  apb       in         psel/penable     paddr, pwdata, prdata (centre, limits)
//
//  - Dead band and centre band samples pass from the prepare state straight to the final state.
//  - Deflected samples run the arctangent unit (zero offset and diagonal excepted):
//    7 steps, each a multiply over TDIG digits, TDIG = ceil((ANGLE_FRAC_BITS + 2) / 4),
//    then a coordinate update; the digit-serial tangent multiply sits inside that unit.
//  - Reset (aresetn low, synchronous) restores centre 460, limits 900/100 and
//    clears the stored heading to 0.
//  - A result waiting on m_ready does not block the next input transaction;
//    a second result stalls in the final state until the output register
//    frees.
// ============================================================================
`default_nettype none

module joystick_direction_angle #(
    parameter int SAMPLE_BITS     = 10,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Input sample transaction
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [SAMPLE_BITS-1:0]      s_x_sample,
    input  wire logic [SAMPLE_BITS-1:0]      s_y_sample,
    // Heading result transaction
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [jda_pkg::HEAD_W-1:0]       m_heading_deg,
    // Register port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [3:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import jda_pkg::*;

    localparam int SW = SAMPLE_BITS;

    // Control state
    jda_state_t        state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    logic [HEAD_W-1:0] last_reg, last_next;
    logic [SW-1:0]     centre_reg, centre_next;
    logic [SW-1:0]     upper_reg, upper_next;
    logic [SW-1:0]     lower_reg, lower_next;

    // Payload
    logic [SW-1:0]     xs_reg, xs_next;
    logic [SW-1:0]     ys_reg, ys_next;
    logic              xhigh_reg, xhigh_next;
    logic              yup_reg, yup_next;
    logic              exact_reg, exact_next;
    logic              map_reg, map_next;
    logic              kern_reg, kern_next;
    logic [KDEG_W-1:0] kfix_reg, kfix_next;
    logic [HEAD_W-1:0] hold_reg, hold_next;
    logic [HEAD_W-1:0] head_reg, head_next;

    // Classification of the held sample pair
    logic              xhigh, xlow, yup, ydn;
    logic [SW-1:0]     a_val, b_val;
    logic              need_kern;
    logic              kern_start, kern_done;
    logic [KDEG_W-1:0] kern_k;
    logic [KDEG_W-1:0] k_sel;
    logic [HEAD_W-1:0] head_fin;
    logic              out_free;
    logic              cfg_wr;
    jda_reg_t          cfg_sel;

    // Quadrant map of the floor angle k onto the compass
    function automatic logic [HEAD_W-1:0] map_heading(input logic xh, input logic yu,
                                                      input logic ex,
                                                      input logic [KDEG_W-1:0] kd);
        logic [HEAD_W-1:0] kk;
        logic [HEAD_W-1:0] h;
        kk = HEAD_W'(kd);
        if (xh && yu) begin
            h = kk;
        end else if (xh) begin
            h = ex ? (DEG_180 - kk) : (DEG_179 - kk);
        end else if (yu) begin
            if (ex) begin
                // full circle wraps to north
                h = (kk == '0) ? DEG_0 : (DEG_360 - kk);
            end else begin
                h = DEG_359 - kk;
            end
        end else begin
            h = DEG_180 + kk;
        end
        return h;
    endfunction

    // Limits: high side first, then low side; Y split at centre and centre - 1
    assign xhigh = xs_reg > upper_reg;
    assign xlow  = !xhigh && (xs_reg < lower_reg);
    assign yup   = ys_reg > centre_reg;
    assign ydn   = (({1'b0, ys_reg} + 1'b1) < {1'b0, centre_reg});

    // Offsets; a negative X offset clamps at zero
    always_comb begin
        if (xhigh) begin
            a_val = (xs_reg > centre_reg) ? (xs_reg - centre_reg) : '0;
        end else begin
            a_val = (centre_reg > xs_reg) ? (centre_reg - xs_reg) : '0;
        end
        b_val = yup ? (ys_reg - centre_reg) : (centre_reg - ys_reg);
    end

    // Zero offset and the diagonal are exact and skip the arctangent unit
    assign need_kern  = (xhigh || xlow) && (yup || ydn) &&
                        (a_val != '0) && (a_val != b_val);
    assign kern_start = (state_reg == ST_PREP) && need_kern;

    jda_atan_serial #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_atan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (kern_start),
        .a       (a_val),
        .b       (b_val),
        .done    (kern_done),
        .k       (kern_k)
    );

    assign k_sel    = kern_reg ? kern_k : kfix_reg;
    assign head_fin = map_reg ? map_heading(xhigh_reg, yup_reg, exact_reg, k_sel)
                              : hold_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Register writes complete in the access phase
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = jda_reg_t'(paddr[3:2]);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        last_next    = last_reg;
        centre_next  = centre_reg;
        upper_next   = upper_reg;
        lower_next   = lower_reg;
        xs_next      = xs_reg;
        ys_next      = ys_reg;
        xhigh_next   = xhigh_reg;
        yup_next     = yup_reg;
        exact_next   = exact_reg;
        map_next     = map_reg;
        kern_next    = kern_reg;
        kfix_next    = kfix_reg;
        hold_next    = hold_reg;
        head_next    = head_reg;

        if (cfg_wr) begin
            case (cfg_sel)
                REG_CENTRE: centre_next = pwdata[SW-1:0];
                REG_UPPER:  upper_next  = pwdata[SW-1:0];
                REG_LOWER:  lower_next  = pwdata[SW-1:0];
                default:    ;  // drop writes past the register list
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    xs_next    = s_x_sample;
                    ys_next    = s_y_sample;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                xhigh_next = xhigh;
                yup_next   = yup;
                exact_next = (a_val == '0) || (a_val == b_val);
                kfix_next  = (a_val == '0) ? '0 : K_45;
                kern_next  = need_kern;
                if (!(xhigh || xlow)) begin
                    // X in dead band: only full Y deflection sets a heading
                    map_next = 1'b0;
                    if (ys_reg > upper_reg) begin
                        hold_next = DEG_0;
                    end else if (ys_reg < lower_reg) begin
                        hold_next = DEG_180;
                    end else begin
                        hold_next = last_reg;
                    end
                    state_next = ST_FIN;
                end else if (!(yup || ydn)) begin
                    map_next   = 1'b0;
                    hold_next  = xhigh ? DEG_90 : DEG_270;
                    state_next = ST_FIN;
                end else begin
                    map_next   = 1'b1;
                    state_next = need_kern ? ST_KERN : ST_FIN;
                end
            end
            ST_KERN: begin
                if (kern_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // Hold here until the output register can take the result
                if (out_free) begin
                    head_next    = head_fin;
                    last_next    = head_fin;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            last_reg    <= '0;
            centre_reg  <= SW'(CENTRE_RESET);
            upper_reg   <= SW'(UPPER_RESET);
            lower_reg   <= SW'(LOWER_RESET);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            last_reg    <= last_next;
            centre_reg  <= centre_next;
            upper_reg   <= upper_next;
            lower_reg   <= lower_next;
        end
    end

    always_ff @(posedge aclk) begin
        xs_reg    <= xs_next;
        ys_reg    <= ys_next;
        xhigh_reg <= xhigh_next;
        yup_reg   <= yup_next;
        exact_reg <= exact_next;
        map_reg   <= map_next;
        kern_reg  <= kern_next;
        kfix_reg  <= kfix_next;
        hold_reg  <= hold_next;
        head_reg  <= head_next;
    end

    // Register readback
    always_comb begin
        case (cfg_sel)
            REG_CENTRE: prdata = 32'(centre_reg);
            REG_UPPER:  prdata = 32'(upper_reg);
            REG_LOWER:  prdata = 32'(lower_reg);
            default:    prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_heading_deg = head_reg;

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> head_reg < DEG_360)
        else $error("heading outside 0..359");

    a_done_in_kern: assert property (@(posedge aclk) disable iff (!aresetn)
        kern_done |-> state_reg == ST_KERN)
        else $error("arctangent result arrived outside the wait state");

    a_load_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result loaded without a finished computation");

    a_last_tracks_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> last_reg == head_reg)
        else $error("stored heading differs from delivered result");

endmodule : joystick_direction_angle

`default_nettype wire

@@ rtl/core/jda_atan_serial.sv @@
// ============================================================================
// jda_atan_serial - floor of atan(a/b) in whole degrees
// Seven pseudo-rotation steps, each with a digit-serial multiply of both
// coordinates by the step tangent.
// ============================================================================
`default_nettype none

module jda_atan_serial #(
    parameter int SAMPLE_BITS     = 10,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [SAMPLE_BITS-1:0]        a,
    input  wire logic [SAMPLE_BITS-1:0]        b,
    output logic                               done,
    output logic [jda_pkg::KDEG_W-1:0]         k
);
    import jda_pkg::*;

    localparam int CW   = SAMPLE_BITS + COORD_GUARD + COORD_HEADROOM;
    localparam int TW   = ANGLE_FRAC_BITS + 2;
    localparam int TDIG = (TW + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int TP   = TDIG * DIGIT_BITS;
    localparam int PW   = CW + TP;
    localparam int QW   = PW - ANGLE_FRAC_BITS;
    localparam int CNTW = $clog2(TDIG + 1);

    jda_kstate_t       state_reg, state_next;
    logic [CW-1:0]     x_reg, x_next;
    logic [CW-1:0]     y_reg, y_next;
    logic [PW-1:0]     accp_reg, accp_next;
    logic [PW-1:0]     accq_reg, accq_next;
    logic [TP-1:0]     tsh_reg, tsh_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [KDEG_W-1:0] k_reg, k_next;
    logic              done_reg, done_next;

    logic [IDX_W-1:0]      tidx;
    logic [TP-1:0]         tan_pad;
    logic [DIGIT_BITS-1:0] dig;
    logic [CW+DIGIT_BITS-1:0] xdig, ydig;
    logic [QW-1:0]         p_val, q_val;
    logic [KDEG_W:0]       k_try;
    logic                  take;

    assign tidx    = (state_reg == KS_IDLE) ? '0 : IDX_W'(idx_reg + 1'b1);
    assign tan_pad = TP'(TW'(tan_const(tidx, ANGLE_FRAC_BITS)));
    assign dig     = tsh_reg[TP-1 -: DIGIT_BITS];
    assign xdig    = (CW+DIGIT_BITS)'(x_reg) * (CW+DIGIT_BITS)'(dig);
    assign ydig    = (CW+DIGIT_BITS)'(y_reg) * (CW+DIGIT_BITS)'(dig);
    assign p_val   = QW'(accp_reg >> ANGLE_FRAC_BITS);
    assign q_val   = QW'(accq_reg >> ANGLE_FRAC_BITS);
    assign k_try   = {1'b0, k_reg} + {1'b0, step_deg(idx_reg)};
    assign take    = (p_val <= QW'(y_reg)) && (k_try <= {1'b0, K_MAX});

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        accp_next  = accp_reg;
        accq_next  = accq_reg;
        tsh_next   = tsh_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        case (state_reg)
            KS_IDLE: begin
                if (start) begin
                    x_next     = CW'(b) << COORD_GUARD;
                    y_next     = CW'(a) << COORD_GUARD;
                    k_next     = '0;
                    idx_next   = '0;
                    tsh_next   = tan_pad;
                    accp_next  = '0;
                    accq_next  = '0;
                    cnt_next   = CNTW'(TDIG);
                    state_next = KS_MUL;
                end
            end
            KS_MUL: begin
                // Accumulate one tangent digit, most significant first
                accp_next = (accp_reg << DIGIT_BITS) + PW'(xdig);
                accq_next = (accq_reg << DIGIT_BITS) + PW'(ydig);
                tsh_next  = tsh_reg << DIGIT_BITS;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    state_next = KS_UPD;
                end
            end
            KS_UPD: begin
                if (take) begin
                    y_next = y_reg - CW'(p_val);
                    x_next = x_reg + CW'(q_val);
                    k_next = KDEG_W'(k_try);
                end
                if (idx_reg == IDX_W'(NUM_STEPS - 1)) begin
                    done_next  = 1'b1;
                    state_next = KS_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    tsh_next   = tan_pad;
                    accp_next  = '0;
                    accq_next  = '0;
                    cnt_next   = CNTW'(TDIG);
                    state_next = KS_MUL;
                end
            end
            default: begin
                state_next = KS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= KS_IDLE;
            done_reg  <= 1'b0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        accp_reg <= accp_next;
        accq_reg <= accq_next;
        tsh_reg  <= tsh_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
    end

    assign done = done_reg;
    assign k    = k_reg;

    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= K_MAX)
        else $error("angle count beyond 89 degrees");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == KS_IDLE)
        else $error("kernel started while busy");

    a_done_after_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(state_reg == KS_UPD))
        else $error("done without a final update step");

endmodule : jda_atan_serial

`default_nettype wire

@@ bench/heading_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// heading_checker - in-order scoreboard for the joystick heading block
// Mirrors the register port, predicts a heading for every accepted sample
// pair and compares each accepted result against the oldest prediction.
// ============================================================================

module heading_checker #(
    parameter int SAMPLE_BITS     = 10,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [SAMPLE_BITS-1:0]       s_x_sample,
    input  logic [SAMPLE_BITS-1:0]       s_y_sample,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [jda_pkg::HEAD_W-1:0]   m_heading_deg,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready,
    output int                           mismatch_count,
    output int                           headings_due
);
    import jda_pkg::*;

    typedef struct {
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
        logic [HEAD_W-1:0]      heading;
    } heading_entry_t;

    logic [SAMPLE_BITS-1:0] centre_q;
    logic [SAMPLE_BITS-1:0] upper_q;
    logic [SAMPLE_BITS-1:0] lower_q;
    logic [HEAD_W-1:0]      last_heading_q;
    heading_entry_t         pending_headings[$];
    int                     fails = 0;

    // Step tangents in Q24, rounded to the configured fraction width
    function automatic longint unsigned step_tangent(input int idx);
        longint unsigned base;
        int              sh;
        case (idx)
            0:       base = 64'd34398390;
            1:       base = 64'd10483568;
            2:       base = 64'd4810789;
            3:       base = 64'd2357884;
            4:       base = 64'd1173177;
            5:       base = 64'd585873;
            default: base = 64'd292847;
        endcase
        sh = 24 - ANGLE_FRAC_BITS;
        if (sh <= 0) begin
            return base;
        end
        return (base + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // Floor of atan(a/b) in degrees by greedy pseudo-rotation, b >= 1
    function automatic int unsigned floor_atan_deg(input longint unsigned a,
                                                   input longint unsigned b);
        longint unsigned xv;
        longint unsigned yv;
        longint unsigned t;
        longint unsigned p;
        longint unsigned q;
        int unsigned     k;
        int unsigned     step;
        xv = b << 8;
        yv = a << 8;
        k  = 0;
        if (a == 0) begin
            return 0;
        end
        if (a == b) begin
            return 45;
        end
        for (int i = 0; i < 7; i++) begin
            step = 64 >> i;
            t    = step_tangent(i);
            p    = (xv * t) >> ANGLE_FRAC_BITS;
            if (p <= yv && k + step <= 89) begin
                q  = (yv * t) >> ANGLE_FRAC_BITS;
                yv = yv - p;
                xv = xv + q;
                k  = k + step;
            end
        end
        return k;
    endfunction

    function automatic logic [HEAD_W-1:0] predict_heading(input int xs, input int ys);
        int              c;
        int              hi;
        int              lo;
        int              da;
        int              h;
        longint unsigned a;
        longint unsigned b;
        int unsigned     k;
        bit              xhigh;
        bit              xlow;
        bit              yup;
        bit              exact;
        c     = centre_q;
        hi    = upper_q;
        lo    = lower_q;
        h     = last_heading_q;
        xhigh = xs > hi;
        xlow  = !xhigh && xs < lo;
        if (xhigh || xlow) begin
            da = xhigh ? (xs - c) : (c - xs);
            a  = (da > 0) ? da : 0;
            if (ys > c || ys < c - 1) begin
                yup   = ys > c;
                b     = yup ? (ys - c) : (c - ys);
                k     = floor_atan_deg(a, b);
                exact = (a == 0) || (a == b);
                if (xhigh && yup) begin
                    h = k;
                end else if (xhigh) begin
                    h = exact ? 180 - int'(k) : 179 - int'(k);
                end else if (yup) begin
                    h = exact ? 360 - int'(k) : 359 - int'(k);
                end else begin
                    h = 180 + int'(k);
                end
                if (h >= 360) begin
                    h = h - 360;
                end
            end else begin
                h = xhigh ? 90 : 270;
            end
        end else begin
            if (ys > hi) begin
                h = 0;
            end else if (ys < lo) begin
                h = 180;
            end
        end
        return HEAD_W'(h);
    endfunction

    task automatic report(input string msg);
        if (fails < 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
        fails++;
    endtask

    always @(posedge aclk) begin : watch
        heading_entry_t    entry;
        logic [HEAD_W-1:0] h;
        logic [31:0]       reg_value;
        bit                readable;
        if (!aresetn) begin
            centre_q       = CENTRE_RESET;
            upper_q        = UPPER_RESET;
            lower_q        = LOWER_RESET;
            last_heading_q = '0;
            pending_headings.delete();
        end else begin
            // Retire results before queuing new samples: a result accepted at
            // this edge can never belong to a sample accepted at the same edge
            if (m_valid && m_ready) begin
                if (pending_headings.size() == 0) begin
                    report($sformatf("heading %0d arrived with no sample pending",
                                     m_heading_deg));
                end else begin
                    entry = pending_headings.pop_front();
                    if (m_heading_deg !== entry.heading) begin
                        report($sformatf("heading for x=%0d y=%0d: expected %0d, got %0d",
                                         entry.x, entry.y, entry.heading, m_heading_deg));
                    end
                end
            end
            if (s_valid && s_ready) begin
                h              = predict_heading(s_x_sample, s_y_sample);
                last_heading_q = h;
                entry.x        = s_x_sample;
                entry.y        = s_y_sample;
                entry.heading  = h;
                pending_headings.push_back(entry);
            end
            if (psel && penable && pready) begin
                readable  = 1'b1;
                reg_value = '0;
                case (jda_reg_t'(paddr[3:2]))
                    REG_CENTRE: begin
                        if (pwrite) centre_q = pwdata[SAMPLE_BITS-1:0];
                        reg_value = 32'(centre_q);
                    end
                    REG_UPPER: begin
                        if (pwrite) upper_q = pwdata[SAMPLE_BITS-1:0];
                        reg_value = 32'(upper_q);
                    end
                    REG_LOWER: begin
                        if (pwrite) lower_q = pwdata[SAMPLE_BITS-1:0];
                        reg_value = 32'(lower_q);
                    end
                    default: begin
                        readable = 1'b0;
                    end
                endcase
                if (!pwrite && readable && prdata !== reg_value) begin
                    report($sformatf("register read at 0x%0h: expected %0d, got %0d",
                                     paddr, reg_value, prdata));
                end
            end
        end
        mismatch_count <= fails;
        headings_due   <= pending_headings.size();
    end

endmodule : heading_checker

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench - joystick heading block regression
// Drives sample pairs and register writes with random idle bursts on both
// channels; a side checker predicts every heading and flags mismatches.
// ============================================================================

module testbench;
    import jda_pkg::*;

    localparam int SAMPLE_BITS      = 10;
    localparam int ANGLE_FRAC_BITS  = 16;
    localparam int SAMPLE_MAX       = (1 << SAMPLE_BITS) - 1;
    // Stall limit sits well above the slowest item (gap, kernel, output stall)
    localparam int STALL_LIMIT      = 4000;
    localparam int TAIL_CYCLES      = 100;
    localparam int RANDOM_PER_PHASE = 55;

    logic                   aclk       = 1'b0;
    logic                   aresetn    = 1'b0;
    logic                   s_valid    = 1'b0;
    logic                   s_ready;
    logic [SAMPLE_BITS-1:0] s_x_sample = '0;
    logic [SAMPLE_BITS-1:0] s_y_sample = '0;
    logic                   m_valid;
    logic                   m_ready    = 1'b0;
    logic [HEAD_W-1:0]      m_heading_deg;
    logic                   psel       = 1'b0;
    logic                   penable    = 1'b0;
    logic                   pwrite     = 1'b0;
    logic [3:0]             paddr      = '0;
    logic [31:0]            pwdata     = '0;
    logic [31:0]            prdata;
    logic                   pready;

    int mismatch_count;
    int headings_due;

    // Idle bursts are allowed until the final phase turns them off
    bit idling_on = 1'b1;

    // Local copy of the register settings, used only to shape stimulus
    int cfg_centre = CENTRE_RESET;
    int cfg_upper  = UPPER_RESET;
    int cfg_lower  = LOWER_RESET;

    joystick_direction_angle #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_x_sample    (s_x_sample),
        .s_y_sample    (s_y_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_heading_deg (m_heading_deg),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    heading_checker #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_checker (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Watchdog: fail and end the run once the stall counter reaches STALL_LIMIT with nothing moving
    initial begin : watchdog
        int stalled_cycles;
        stalled_cycles = 0;
        while (stalled_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (psel && penable && pready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    // Result side: hold m_ready low in random bursts, with long open stretches
    initial begin : result_sink
        while (!aresetn) @(posedge aclk);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end
        end
    end

    // Offer one sample pair and hold it until the transaction completes.
    // Call right after a rising edge; returns in the step of the accepting edge.
    task automatic push_sample(input int x, input int y);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_x_sample <= SAMPLE_BITS'(x);
        s_y_sample <= SAMPLE_BITS'(y);
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every predicted heading has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (headings_due != 0) @(posedge aclk);
    endtask

    // APB transaction: setup cycle, then access cycle until pready
    task automatic apb_access(input jda_reg_t idx, input bit wr, input int value);
        logic [31:0] data;
        data                    = $urandom();
        data[SAMPLE_BITS-1:0]   = SAMPLE_BITS'(value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Program all three registers (upper data bits random), poke the unused
    // slot, then read everything back
    task automatic set_limits(input int c, input int hi, input int lo);
        apb_access(REG_CENTRE, 1'b1, c);
        apb_access(REG_UPPER, 1'b1, hi);
        apb_access(REG_LOWER, 1'b1, lo);
        apb_access(REG_NONE, 1'b1, $urandom_range(SAMPLE_MAX, 0));
        apb_access(REG_CENTRE, 1'b0, 0);
        apb_access(REG_UPPER, 1'b0, 0);
        apb_access(REG_LOWER, 1'b0, 0);
        apb_access(REG_NONE, 1'b0, 0);
        cfg_centre = c;
        cfg_upper  = hi;
        cfg_lower  = lo;
    endtask

    // Favor deflected X so that most samples reach the arctangent path
    function automatic int pick_x();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && cfg_upper < SAMPLE_MAX) begin
            return $urandom_range(SAMPLE_MAX, cfg_upper + 1);
        end
        if (r < 8 && cfg_lower > 0) begin
            return $urandom_range(cfg_lower - 1, 0);
        end
        return $urandom_range(SAMPLE_MAX, 0);
    endfunction

    // Mostly full range, sometimes right around the centre band
    function automatic int pick_y();
        int v;
        if ($urandom_range(0, 7) == 0) begin
            v = cfg_centre + int'($urandom_range(0, 4)) - 2;
            if (v < 0) v = 0;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
            return v;
        end
        return $urandom_range(SAMPLE_MAX, 0);
    endfunction

    task automatic random_phase(input int count);
        repeat (count) push_sample(pick_x(), pick_y());
        drain();
    endtask

    initial begin : stimulus
        int c;
        int hi;
        int lo;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Check the reset values of the registers
        apb_access(REG_CENTRE, 1'b0, 0);
        apb_access(REG_UPPER, 1'b0, 0);
        apb_access(REG_LOWER, 1'b0, 0);

        // Directed samples at the reset settings (centre 460, limits 900/100)
        push_sample(SAMPLE_MAX, SAMPLE_MAX);  // a equals b, 45
        push_sample(SAMPLE_MAX, 461);         // steep, angle saturates at 89
        push_sample(SAMPLE_MAX, 460);         // centre band, upper edge
        push_sample(SAMPLE_MAX, 459);         // centre band, lower edge
        push_sample(SAMPLE_MAX, 458);         // just below band, 180 - alpha
        push_sample(SAMPLE_MAX, 0);
        push_sample(910, 10);                 // a equals b below centre, 135
        push_sample(901, SAMPLE_MAX);         // first X above the upper limit
        push_sample(900, SAMPLE_MAX);         // X at the limit is dead band
        push_sample(0, SAMPLE_MAX);           // 360 - alpha, truncated
        push_sample(0, 920);                  // a equals b, 315
        push_sample(0, 0);                    // 180 + 45
        push_sample(0, 460);                  // centre band, 270
        push_sample(99, 700);                 // first X below the lower limit
        push_sample(100, 0);                  // dead band X, Y low gives 180
        push_sample(500, 901);                // dead band X, Y high gives 0
        push_sample(500, 900);                // dead band both, hold
        push_sample(500, 99);
        push_sample(SAMPLE_MAX, 700);
        push_sample(500, 100);                // hold the last heading
        drain();

        // Centre above the upper limit: zero and negative X offsets
        set_limits(950, 900, 100);
        push_sample(950, SAMPLE_MAX);         // zero offset, heading 0
        push_sample(950, 0);                  // zero offset, exact 180
        push_sample(920, 1000);               // negative offset clamps to zero
        drain();

        // Centre below the lower limit: 360 folds to 0
        set_limits(50, 900, 100);
        push_sample(50, SAMPLE_MAX);
        push_sample(60, 0);
        drain();

        // Random phases across typical and extreme settings
        set_limits(CENTRE_RESET, UPPER_RESET, LOWER_RESET);
        random_phase(RANDOM_PER_PHASE);
        set_limits(0, SAMPLE_MAX, 0);
        random_phase(20);
        set_limits(SAMPLE_MAX, 0, SAMPLE_MAX);
        random_phase(RANDOM_PER_PHASE);
        set_limits(0, 0, SAMPLE_MAX);
        random_phase(RANDOM_PER_PHASE);
        set_limits(512, 600, 400);
        random_phase(RANDOM_PER_PHASE);
        repeat (3) begin
            lo = $urandom_range(500, 0);
            hi = $urandom_range(SAMPLE_MAX, lo);
            c  = $urandom_range(hi, lo);
            set_limits(c, hi, lo);
            random_phase(RANDOM_PER_PHASE);
        end
        set_limits($urandom_range(SAMPLE_MAX, 0), $urandom_range(SAMPLE_MAX, 0),
                   $urandom_range(SAMPLE_MAX, 0));
        random_phase(RANDOM_PER_PHASE);

        // Final stretch at full rate on both sides
        idling_on = 1'b0;
        set_limits(CENTRE_RESET, UPPER_RESET, LOWER_RESET);
        random_phase(RANDOM_PER_PHASE);

        // Let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && headings_due == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule : testbench

@@ filelist.f @@
rtl/core/jda_pkg.sv
rtl/core/jda_atan_serial.sv
rtl/core/joystick_direction_angle.sv
bench/heading_checker.sv
bench/testbench.sv
